@@ rtl/bba_pkg.sv @@
`default_nettype none
// ============================================================================
// bba_pkg
// Shared types, widths and codes of the bitmap block allocator.
// ============================================================================
package bba_pkg;

  localparam int TOTAL_W    = 13;
  localparam int START_W    = 24;
  localparam int SHIFT_W    = 3;
  localparam int OFFS_W     = 25;
  localparam int STAT_W     = 2;
  localparam int CNT_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int MAX_BLOCKS_DEF = 4096;

  localparam logic [TOTAL_W-1:0] TOTAL_RST = 13'd4096;
  localparam logic [START_W-1:0] START_RST = 24'd0;
  localparam logic [SHIFT_W-1:0] SHIFT_RST = 3'd1;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_ALLOC = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL_BLOCKS = 2'd0,
    REG_DATA_START   = 2'd1,
    REG_BLOCK_SHIFT  = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FREE_CALC,
    S_FREE_CHK,
    S_SCAN,
    S_DONE
  } eng_state_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total_blocks;
    logic [START_W-1:0] data_start;
    logic [SHIFT_W-1:0] block_shift;
  } cfg_t;

  typedef struct packed {
    logic              func;
    logic [OFFS_W-1:0] block_offset;
  } request_t;

  typedef struct packed {
    status_t           status;
    logic [OFFS_W-1:0] alloc_offset;
    logic [CNT_W-1:0]  free_count;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/bba_if.sv @@
`default_nettype none
// ============================================================================
// bba_if
// Valid/ready channels of the allocator: request and response.
// ============================================================================
interface bba_req_if import bba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [OFFS_W-1:0] block_offset;

  modport source (output valid, func, block_offset, input ready);
  modport sink   (input valid, func, block_offset, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [OFFS_W-1:0] alloc_offset;
  logic [CNT_W-1:0]  free_count;

  modport source (output valid, status, alloc_offset, free_count, input ready);
  modport sink   (input valid, status, alloc_offset, free_count, output ready);
endinterface
`default_nettype wire

@@ rtl/bitmap_block_allocator.sv @@
`default_nettype none
// ============================================================================
// bitmap_block_allocator
// First-fit block allocator over a used-block bitmap held in block RAM.
// ============================================================================
//
//   Channel   Direction  Transaction contents
//   -------   ---------  ---------------------------------------------------
//   in_req    sink       func (0 allocate, 1 free), block_offset (sector)
//   out_rsp   source     status, alloc_offset, free_count
//   cfg_*     write      cfg_we, cfg_index, cfg_wdata (no read-back)
//
// An allocate scans one bitmap byte per cycle, set by the single RAM read
// port, until it finds a clear usable bit or reaches the end of the map.
// A free runs an address check, a RAM read, a write back and the result;
// the write back is skipped when the address is out of range or the block
// is not allocated. After reset a clearing pass writes every bitmap byte,
// one per cycle, before the first request transaction is accepted. The
// response register lets the next request start while a result waits for
// out_rsp.ready.
// ============================================================================
module bitmap_block_allocator import bba_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  bba_req_if.sink                    in_req,
  bba_rsp_if.source                  out_rsp,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEPTH = (MAX_BLOCKS + 7) / 8;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration registers; to be written only while the block is idle, which the block itself does not enforce.
  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TOTAL_BLOCKS: cfg_nxt.total_blocks = cfg_wdata[TOTAL_W-1:0];
        REG_DATA_START:   cfg_nxt.data_start   = cfg_wdata[START_W-1:0];
        REG_BLOCK_SHIFT:  cfg_nxt.block_shift  = cfg_wdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{total_blocks: TOTAL_RST, data_start: START_RST, block_shift: SHIFT_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Engine and bitmap RAM.
  request_t      req;
  result_t       res;
  logic          res_vld;
  logic          res_take;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  assign req = '{func: in_req.func, block_offset: in_req.block_offset};

  bba_engine #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .DEPTH      (DEPTH),
    .AW         (AW)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .in_req    (req),
    .res_vld   (res_vld),
    .res       (res),
    .res_take  (res_take),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  bba_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  // Response register: loads a finished result whenever it is empty or its
  // current transaction completes in the same cycle.
  logic    out_vld_r, out_vld_nxt;
  result_t out_r, out_nxt;

  always_comb begin
    res_take    = res_vld && (!out_vld_r || out_rsp.ready);
    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;
    if (out_vld_r && out_rsp.ready) begin
      out_vld_nxt = 1'b0;
    end
    if (res_take) begin
      out_vld_nxt = 1'b1;
      out_nxt     = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_rsp.valid        = out_vld_r;
  assign out_rsp.status       = out_r.status;
  assign out_rsp.alloc_offset = out_r.alloc_offset;
  assign out_rsp.free_count   = out_r.free_count;

`ifndef SYNTH
  // One request at a time: after an accepted request the input stalls.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> !in_req.ready)
    else $error("request accepted while another is in flight");

  // Only a successful allocate reports a sector address.
  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && (out_rsp.status != ST_OK) |-> out_rsp.alloc_offset == '0)
    else $error("nonzero alloc_offset on a failed request");

  // The free count never exceeds the configured total.
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid |-> out_rsp.free_count <= cfg_r.total_blocks)
    else $error("free_count above total_blocks");
`endif

endmodule
`default_nettype wire

@@ rtl/bba_ram.sv @@
`default_nettype none
// ============================================================================
// bba_ram
// Byte-wide bitmap store: one write port, one read port, registered read.
// ============================================================================
module bba_ram #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata_r
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/bba_engine.sv @@
`default_nettype none
// ============================================================================
// bba_engine
// Request sequencer: clearing pass, first-fit scan and free read-modify-write.
// ============================================================================
module bba_engine import bba_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int DEPTH      = (MAX_BLOCKS + 7) / 8,
  parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cfg_t          cfg,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire request_t      in_req,
  output logic               res_vld,
  output result_t            res,
  input  wire logic          res_take,
  output logic               mem_we,
  output logic      [AW-1:0] mem_waddr,
  output logic      [7:0]    mem_wdata,
  output logic      [AW-1:0] mem_raddr,
  input  wire logic [7:0]    mem_rdata
);

  localparam int IDX_W = AW + 3;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int MB_W  = $clog2(MAX_BLOCKS + 1);
  localparam int ET_W  = (MB_W > TOTAL_W) ? MB_W : TOTAL_W;
  localparam logic [ET_W-1:0] MAX_ET   = ET_W'(MAX_BLOCKS);
  localparam logic [AW-1:0]   LAST_W   = AW'(DEPTH - 1);

  eng_state_t        state_r, state_nxt;
  logic              func_r, func_nxt;
  logic [OFFS_W-1:0] addr_r, addr_nxt;
  logic [CW-1:0]     scan_w_r, scan_w_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]     chk_w_r, chk_w_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  status_t           status_r, status_nxt;
  logic [CNT_W-1:0]  used_cnt_r, used_cnt_nxt;
  logic [AW-1:0]     clr_w_r, clr_w_nxt;

  logic [ET_W-1:0]   tot_ext;
  logic [ET_W-1:0]   eff_total;
  logic [ET_W:0]     et_round;
  logic [CW-1:0]     numw;
  logic              issue;
  logic              word_full;
  logic [7:0]        cand;
  logic              found;
  logic [2:0]        kf;
  logic              below;
  logic [OFFS_W-1:0] diff;
  logic [OFFS_W-1:0] sh;
  logic              oor;
  logic              cur_bit;
  logic [ET_W-1:0]   cnt_ext;
  logic [OFFS_W-1:0] ofs_sum;

  // Effective total, words to scan, per-word candidate search, free address checks and result offset.
  always_comb begin
    tot_ext   = ET_W'(cfg.total_blocks);
    eff_total = (tot_ext > MAX_ET) ? MAX_ET : tot_ext;
    et_round  = {1'b0, eff_total} + (ET_W + 1)'(7);
    numw      = CW'(et_round >> 3);
    issue     = (scan_w_r < numw);
    word_full = (ET_W'(chk_w_r) < (eff_total >> 3));
    for (int k = 0; k < 8; k++) begin
      cand[k] = (word_full || (3'(k) < eff_total[2:0])) && !mem_rdata[7-k];
    end
    found = |cand;
    kf    = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (cand[k]) begin
        kf = 3'(k);
      end
    end
    below   = (addr_r < OFFS_W'(cfg.data_start));
    diff    = addr_r - OFFS_W'(cfg.data_start);
    sh      = diff >> cfg.block_shift;
    oor     = below || (sh >= OFFS_W'(eff_total));
    cur_bit = mem_rdata[3'd7 - idx_r[2:0]];
    cnt_ext = ET_W'(used_cnt_r);
    ofs_sum = OFFS_W'(cfg.data_start) + (OFFS_W'(idx_r) << cfg.block_shift);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_w_r == LAST_W) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_req.func == FUNC_FREE) ? S_FREE_CALC : S_SCAN;
        end
      end
      S_FREE_CALC: begin
        state_nxt = oor ? S_DONE : S_FREE_CHK;
      end
      S_FREE_CHK: begin
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        if ((chk_vld_r && found) || !issue) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs, memory controls and datapath updates.
  always_comb begin
    in_ready     = 1'b0;
    res_vld      = 1'b0;
    res          = '{status: status_r, alloc_offset: '0, free_count: '0};
    mem_we       = 1'b0;
    mem_waddr    = clr_w_r;
    mem_wdata    = 8'h00;
    mem_raddr    = scan_w_r[AW-1:0];
    func_nxt     = func_r;
    addr_nxt     = addr_r;
    scan_w_nxt   = scan_w_r;
    chk_vld_nxt  = 1'b0;
    chk_w_nxt    = chk_w_r;
    idx_nxt      = idx_r;
    status_nxt   = status_r;
    used_cnt_nxt = used_cnt_r;
    clr_w_nxt    = clr_w_r;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        clr_w_nxt = clr_w_r + AW'(1);
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        func_nxt   = in_req.func;
        addr_nxt   = in_req.block_offset;
        scan_w_nxt = '0;
        status_nxt = ST_OK;
      end
      S_FREE_CALC: begin
        mem_raddr = sh[IDX_W-1:3];
        idx_nxt   = sh[IDX_W-1:0];
        if (oor) begin
          status_nxt = ST_RANGE;
        end
      end
      S_FREE_CHK: begin
        if (!cur_bit) begin
          status_nxt = ST_NOT_ALLOC;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = idx_r[IDX_W-1:3];
          mem_wdata = mem_rdata & ~(8'h80 >> idx_r[2:0]);
          if (used_cnt_r != '0) begin
            used_cnt_nxt = used_cnt_r - CNT_W'(1);
          end
        end
      end
      S_SCAN: begin
        // One word read per cycle; its data is checked in the cycle after the read.
        chk_vld_nxt = issue;
        chk_w_nxt   = scan_w_r[AW-1:0];
        if (issue) begin
          scan_w_nxt = scan_w_r + CW'(1);
        end
        if (chk_vld_r && found) begin
          chk_vld_nxt  = 1'b0;
          mem_we       = 1'b1;
          mem_waddr    = chk_w_r;
          mem_wdata    = mem_rdata | (8'h80 >> kf);
          idx_nxt      = {chk_w_r, kf};
          used_cnt_nxt = used_cnt_r + CNT_W'(1);
        end else if (!issue) begin
          status_nxt = ST_FULL;
        end
      end
      S_DONE: begin
        res_vld = 1'b1;
        if (status_r == ST_OK && func_r == FUNC_ALLOC) begin
          res.alloc_offset = ofs_sum;
        end
        if (eff_total > cnt_ext) begin
          res.free_count = CNT_W'(eff_total - cnt_ext);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      used_cnt_r <= '0;
      clr_w_r    <= '0;
      chk_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      used_cnt_r <= used_cnt_nxt;
      clr_w_r    <= clr_w_nxt;
      chk_vld_r  <= chk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    addr_r   <= addr_nxt;
    scan_w_r <= scan_w_nxt;
    chk_w_r  <= chk_w_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
  end

endmodule
`default_nettype wire

@@ tb/sv/tb_bitmap_block_allocator.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_bitmap_block_allocator
// Self-checking testbench for the first-fit bitmap block allocator. Requests
// go through the valid/ready request channel, and a behavioral model of the
// allocator predicts every response. A checker process compares each response
// with the oldest prediction. Directed tests cover the address and total
// extremes. Random traffic then runs under three idling patterns.
// ============================================================================
module tb_bitmap_block_allocator;
  import bba_pkg::*;

  // Generous cycle budget. A full-length allocate scan reads every bitmap byte,
  // the clearing pass after reset writes every byte, and stalls on both
  // channels stretch every transaction.
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bba_req_if req_if ();
  bba_rsp_if rsp_if ();

  bitmap_block_allocator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_if),
    .out_rsp   (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Allocator model state. It mirrors the register settings and keeps one
  // used flag per block. The order of bits inside a byte cannot be seen at
  // the ports, so a flat array per block is enough. held_blocks lists the
  // used block indexes, so that the stimulus can free real allocations.
  // --------------------------------------------------------------------------
  logic [TOTAL_W-1:0] cfg_total = TOTAL_RST;
  logic [START_W-1:0] cfg_start = START_RST;
  logic [SHIFT_W-1:0] cfg_shift = SHIFT_RST;
  bit                 blk_used [MAX_BLOCKS_DEF];
  int unsigned        used_blocks = 0;
  int unsigned        held_blocks [$];

  result_t     pending_results [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned req_gap_pct = 0;
  int unsigned rsp_stall_pct = 0;

  // Clock with a 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The watchdog stops a hung run. Each cycle is counted from time zero.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // The response sink stalls at random. On each cycle, ready is low with
  // probability rsp_stall_pct. Only one update is made per edge.
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Model helpers
  // --------------------------------------------------------------------------

  // A total above the bitmap capacity acts as the full capacity.
  function automatic int unsigned usable_blocks();
    return (cfg_total > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : int'(cfg_total);
  endfunction

  // Compute the response to one accepted request, and update the bitmap,
  // the used count and the list of held blocks to match.
  function automatic result_t predict_request(logic fn, logic [OFFS_W-1:0] offs);
    result_t     rsp;
    int unsigned lim;
    int unsigned idx;
    int unsigned addr;
    logic [31:0] sector;
    bit          hit;
    lim              = usable_blocks();
    rsp.status       = ST_OK;
    rsp.alloc_offset = '0;
    hit              = 1'b0;
    if (fn == FUNC_ALLOC) begin
      // First fit: take the lowest clear block below the usable total.
      for (idx = 0; idx < lim; idx++) begin
        if (!blk_used[idx]) begin
          hit = 1'b1;
          break;
        end
      end
      if (!hit) begin
        rsp.status = ST_FULL;
      end else begin
        blk_used[idx] = 1'b1;
        used_blocks++;
        held_blocks.push_back(idx);
        sector           = cfg_start + (idx << cfg_shift);
        rsp.alloc_offset = sector[OFFS_W-1:0];
      end
    end else begin
      addr = 32'(offs);
      if (addr < cfg_start) begin
        rsp.status = ST_RANGE;
      end else begin
        // Any sector bits below the block size are dropped.
        idx = (addr - cfg_start) >> cfg_shift;
        if (idx >= lim) begin
          rsp.status = ST_RANGE;
        end else if (!blk_used[idx]) begin
          rsp.status = ST_NOT_ALLOC;
        end else begin
          blk_used[idx] = 1'b0;
          if (used_blocks > 0) used_blocks--;
          foreach (held_blocks[i]) begin
            if (held_blocks[i] == idx) begin
              held_blocks.delete(i);
              break;
            end
          end
        end
      end
    end
    // The free count saturates at zero when the total drops below the number
    // of used blocks.
    rsp.free_count = (lim > used_blocks) ? CNT_W'(lim - used_blocks) : '0;
    return rsp;
  endfunction

  // Return the sector address of a block under the current settings. The
  // low bits below the block size can be filled at random.
  function automatic logic [OFFS_W-1:0] block_sector(int unsigned idx, bit ragged);
    logic [31:0] sector;
    sector = cfg_start + (idx << cfg_shift);
    if (ragged) sector = sector + ($urandom & ((32'd1 << cfg_shift) - 1));
    return sector[OFFS_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
             $time, what, got, want);
  endtask

  // The response checker runs at each rising edge. A transaction counts only
  // when valid and ready are both high at that edge. The values sampled here
  // are the ones that the block and the sink drove before the edge.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("response with no request pending", 32'(rsp_if.status), 0);
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.status !== want.status)
          report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
        if (rsp_if.alloc_offset !== want.alloc_offset)
          report_mismatch("alloc_offset", 32'(rsp_if.alloc_offset),
                          32'(want.alloc_offset));
        if (rsp_if.free_count !== want.free_count)
          report_mismatch("free_count", 32'(rsp_if.free_count),
                          32'(want.free_count));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------

  // Send one request transaction. The sender may first idle for some cycles
  // with valid low. Unless the sender idles, valid stays high from one request
  // to the next, so it is never lowered and raised in the same step. The model
  // runs at the edge where the transaction is accepted.
  task automatic send_request(input logic fn, input logic [OFFS_W-1:0] offs);
    while ($urandom_range(99) < req_gap_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.func         <= fn;
    req_if.block_offset <= offs;
    do @(posedge clk); while (!req_if.ready);
    pending_results.push_back(predict_request(fn, offs));
  endtask

  // Stop sending, then wait until every pending response has arrived. A few
  // more cycles let the engine settle back to idle.
  task automatic drain_requests();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Write all three registers while the block is idle, and copy the settings
  // into the model.
  task automatic apply_settings(input logic [TOTAL_W-1:0] total,
                                input logic [START_W-1:0] start,
                                input logic [SHIFT_W-1:0] shift);
    drain_requests();
    write_register(REG_TOTAL_BLOCKS, CFG_DATA_W'(total));
    write_register(REG_DATA_START, start);
    write_register(REG_BLOCK_SHIFT, CFG_DATA_W'(shift));
    cfg_we    <= 1'b0;
    cfg_total = total;
    cfg_start = start;
    cfg_shift = shift;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Run with the reset settings (4096 blocks, start 0, two sectors per
  // block): first fit, reuse of a freed block, an unaligned free, a free of
  // a clear bit, and frees at the top of the range and just past it.
  task automatic test_reset_defaults();
    send_request(FUNC_FREE, '0);                  // nothing allocated yet
    send_request(FUNC_ALLOC, '1);                 // offset field is ignored
    send_request(FUNC_ALLOC, '0);
    send_request(FUNC_FREE, OFFS_W'(3));          // unaligned, clears block 1
    send_request(FUNC_ALLOC, OFFS_W'(12345));     // takes block 1 again
    send_request(FUNC_FREE, '1);                  // far out of range
    send_request(FUNC_FREE, OFFS_W'(8192));       // index equal to the total
    send_request(FUNC_FREE, OFFS_W'(8191));       // last block, still clear
  endtask

  // Use the extreme settings: a total above capacity, the highest data start
  // and the largest block size.
  task automatic test_address_extremes();
    apply_settings('1, '1, '1);
    send_request(FUNC_FREE, '0);                  // below the data start
    send_request(FUNC_FREE, block_sector(MAX_BLOCKS_DEF - 1, 1'b0) + OFFS_W'(127));
    send_request(FUNC_FREE, block_sector(MAX_BLOCKS_DEF, 1'b0));
    send_request(FUNC_ALLOC, '0);
    send_request(FUNC_FREE, block_sector(2, 1'b1));
    send_request(FUNC_ALLOC, '1);
  endtask

  // Fill a small map, then lower the total below the used count. Allocation
  // then reports full and the free count stays at zero. A total of zero
  // rejects everything.
  task automatic test_total_below_used();
    apply_settings(TOTAL_W'(8), '0, '0);
    repeat (6) send_request(FUNC_ALLOC, '0);      // the last one finds it full
    apply_settings(TOTAL_W'(4), '0, '0);
    send_request(FUNC_ALLOC, '0);
    send_request(FUNC_FREE, OFFS_W'(6));          // held, but above the total
    send_request(FUNC_FREE, OFFS_W'(2));
    apply_settings('0, '0, '0);
    send_request(FUNC_ALLOC, '0);
    send_request(FUNC_FREE, '0);
    apply_settings(TOTAL_W'(8), '0, '0);
    send_request(FUNC_FREE, OFFS_W'(2));          // freed before, now clear
  endtask

  // Random requests under one setting. Most requests are allocations, or
  // frees of blocks that are really held. The rest free random blocks in
  // range (up to one past the top) or arbitrary sector addresses.
  task automatic run_random_phase(input logic [TOTAL_W-1:0] total,
                                  input logic [START_W-1:0] start,
                                  input logic [SHIFT_W-1:0] shift,
                                  input int unsigned count,
                                  input int unsigned alloc_pct);
    int unsigned pick;
    int unsigned idx;
    apply_settings(total, start, shift);
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < alloc_pct) begin
        send_request(FUNC_ALLOC, OFFS_W'($urandom));
      end else if (pick < 88 && held_blocks.size() != 0) begin
        idx = held_blocks[$urandom_range(held_blocks.size() - 1)];
        send_request(FUNC_FREE, block_sector(idx, 1'($urandom_range(1))));
      end else if (pick < 95) begin
        idx = $urandom_range(usable_blocks());
        send_request(FUNC_FREE, block_sector(idx, 1'($urandom_range(1))));
      end else begin
        send_request(FUNC_FREE, OFFS_W'($urandom));
      end
    end
  endtask

  // Random traffic under three idling patterns: a sender that seldom idles
  // with a busy sink, then the reverse, then both sides at full rate. The
  // bitmap state carries over from one setting to the next.
  task automatic test_random_traffic();
    req_gap_pct   = 15;
    rsp_stall_pct = 56;
    run_random_phase(TOTAL_W'(16), '0, '0, 120, 50);
    run_random_phase('1, START_W'(100), SHIFT_W'(3), 120, 60);
    run_random_phase(TOTAL_W'(37), '1, '1, 120, 50);
    req_gap_pct   = 56;
    rsp_stall_pct = 15;
    run_random_phase(TOTAL_W'(1), START_W'(5), SHIFT_W'(2), 80, 45);
    run_random_phase(TOTAL_W'(300), START_W'($urandom), SHIFT_W'(1), 140, 70);
    run_random_phase(TOTAL_W'(9), '0, SHIFT_W'(5), 100, 50);
    req_gap_pct   = 0;
    rsp_stall_pct = 0;
    run_random_phase(TOTAL_W'(4096), START_W'($urandom), SHIFT_W'(4), 150, 60);
    run_random_phase(TOTAL_W'(64), START_W'(1), SHIFT_W'(6), 150, 55);
    run_random_phase('0, START_W'($urandom), SHIFT_W'($urandom), 30, 50);
    run_random_phase(TOTAL_W'(24), START_W'($urandom), SHIFT_W'($urandom), 90, 50);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence. Reset is held, then released. The block then runs its
  // clearing pass and holds off the first request until the pass is done.
  // --------------------------------------------------------------------------
  initial begin
    rst_n               <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.func         <= FUNC_ALLOC;
    req_if.block_offset <= '0;
    cfg_we              <= 1'b0;
    cfg_index           <= REG_TOTAL_BLOCKS;
    cfg_wdata           <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_address_extremes();
    test_total_below_used();
    test_random_traffic();

    drain_requests();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
